@@ rtl/ptrf_pkg.sv @@
package ptrf_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 3;
    localparam int PIPE_DEPTH    = CORDIC_LAT + 4;

    localparam int DEG_RANGE = 180;
    localparam int ANGLE_ONE = 65536;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [1:0] LAST_ROW = 2'd2;

    // register indexes
    localparam logic REG_ROT_SOURCE  = 1'b0;
    localparam logic REG_EULER_ORDER = 1'b1;

    // rotation_source codes
    localparam logic SRC_QUAT  = 1'b0;
    localparam logic SRC_EULER = 1'b1;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZXY = 3'd4,
        ORD_ZYX = 3'd5
    } order_t;

    typedef logic signed [31:0] mat32_t [0:2][0:2];
    typedef logic signed [35:0] mat36_t [0:2][0:2];
    typedef logic signed [32:0] mat33_t [0:2][0:2];

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] qw;
        logic signed [31:0] qi;
        logic signed [31:0] qj;
        logic signed [31:0] qk;
        logic               source;
        logic [2:0]         order;
    } side_t;

    // shift and subtract quotient for the constant tables, operands nonnegative
    function automatic longint long_div(longint num, longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (longint'(1) <<< b);
            end
        end
        return quo;
    endfunction

    // pi in Q.56 from machin's formula with truncating series
    function automatic longint pi56_calc();
        longint m;
        longint t;
        longint sum;
        longint k;
        longint pi60;
        bit     neg;
        pi60 = 0;
        for (int idx = 0; idx < 2; idx++) begin
            m = (idx == 0) ? 64'sd5 : 64'sd239;
            t = long_div(longint'(1) <<< 60, m);
            sum = 0;
            k = 1;
            neg = 1'b0;
            while (t > 0) begin
                if (neg) sum = sum - long_div(t, k);
                else     sum = sum + long_div(t, k);
                neg = !neg;
                t = long_div(t, m * m);
                k = k + 2;
            end
            if (idx == 0) pi60 = pi60 + 16 * sum;
            else          pi60 = pi60 - 4 * sum;
        end
        return (pi60 + 8) >>> 4;
    endfunction

    localparam longint PI_Q56 = pi56_calc();
    localparam longint RAD_PER_DEG_Q40 = PI_Q56 / (DEG_RANGE * ANGLE_ONE);

    // atan(2^-i) in Q.56 radians
    function automatic longint atan_q56(int i);
        longint sum;
        longint k;
        longint term;
        int     e;
        bit     neg;
        sum = 0;
        k = 1;
        neg = 1'b0;
        e = 56 - i;
        if (i == 0) begin
            sum = (PI_Q56 + 2) >>> 2;
        end else begin
            while (e >= 0) begin
                term = long_div(longint'(1) <<< e, k);
                if (neg) sum = sum - term;
                else     sum = sum + term;
                neg = !neg;
                k = k + 2;
                e = e - 2 * i;
            end
        end
        return sum;
    endfunction

    function automatic logic signed [32:0] sat33(logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        hi = 37'sd4294967295;
        lo = -37'sd4294967296;
        if (v > hi)      return hi[32:0];
        else if (v < lo) return lo[32:0];
        else             return v[32:0];
    endfunction

    // diag + 2*(e1 + e2), rounded from Q.60 to Q.30, halves up
    function automatic logic signed [32:0] quat_entry(logic diag,
                                                      logic signed [64:0] e1,
                                                      logic signed [64:0] e2);
        logic signed [66:0] s;
        logic signed [36:0] v;
        s = 67'(e1) + 67'(e2);
        s = (s <<< 1) + 67'sd536870912;
        v = 37'(s >>> 30);
        if (diag) v = v + 37'sd1073741824;
        return sat33(v);
    endfunction

endpackage

@@ rtl/pose_vector_to_rigid_transform.sv @@
// pose to rigid transform
// input channel s_*: one pose per transaction (translation, quaternion,
// three euler angles in degrees). result channel m_*: three transactions per
// pose, rows 0, 1, 2 of the top of the homogeneous transform; m_tuser holds
// the row number and m_tlast marks row 2.
// cfg_wr_en/cfg_index/cfg_wdata write rotation_source (index 0) and
// euler_order (index 1); write them only while no pose is in flight.
// path from the input transaction to row 0: fold, scale, a register for
// each cordic stage, sign fix, a multiply register and a sum-and-round
// register for each 3x3 product, then the row register. the quaternion
// formula runs alongside the second product.
// throughput: set by the three result rows per pose that share the result
// channel; the pipeline takes a pose every cycle while s_tready is high.
// a stall on m_tready holds the row register; once the pipeline's last
// stage is also full, s_tready drops and the whole pipeline freezes in place.
// reset (synchronous, active low) empties the pipeline and the row register
// and sets rotation_source to euler mode and euler_order to 0.
module pose_vector_to_rigid_transform (
    input  logic           aclk,
    input  logic           aresetn,
    // tdata: trans_x, trans_y, trans_z, quat_w, quat_i, quat_j, quat_k,
    //        angle_about_x, angle_about_y, angle_about_z, zero pad
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [303:0]   s_tdata,
    // tdata: rot_first, rot_second, rot_third, shift_entry, zero pad
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [135:0]   m_tdata,
    // tuser: row_number
    output logic [1:0]     m_tuser,
    output logic           m_tlast,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [2:0]     cfg_wdata
);

    localparam int LC = ptrf_pkg::CORDIC_LAT;
    localparam int L  = ptrf_pkg::PIPE_DEPTH;

    // config registers
    logic       source_reg, source_next;
    logic [2:0] order_reg, order_next;

    // pipeline valid bits and side data
    logic [L-1:0]    vpipe_reg, vpipe_next;
    ptrf_pkg::side_t side_reg [0:L-1];
    ptrf_pkg::side_t side_in;
    logic            en;

    // cordic results
    logic signed [31:0] xc, xs, yc, ys, zc, zs;

    // euler matrices
    ptrf_pkg::mat32_t mx, my, mz, mi;
    ptrf_pkg::mat32_t fa, fb, fc;
    ptrf_pkg::mat32_t c_dly_reg [0:1];
    ptrf_pkg::mat36_t t_full, r_full;
    ptrf_pkg::mat32_t t_in;

    // quaternion path
    ptrf_pkg::side_t    qside;
    logic signed [63:0] x2_reg, y2_reg, z2_reg, xy_reg, xz_reg, yz_reg;
    logic signed [63:0] wx_reg, wy_reg, wz_reg;
    ptrf_pkg::mat33_t   quat_reg, quat_next;

    // final select and row serializer
    ptrf_pkg::side_t    fside;
    ptrf_pkg::mat33_t   rot_fin;
    logic               vf, load;
    logic               ser_valid_reg, ser_valid_next;
    logic [1:0]         row_reg, row_next;
    ptrf_pkg::mat33_t   rot_reg;
    logic signed [31:0] trans_reg [0:2];

    // configuration writes
    always_comb begin
        source_next = source_reg;
        order_next  = order_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ptrf_pkg::REG_ROT_SOURCE:  source_next = cfg_wdata[0];
                ptrf_pkg::REG_EULER_ORDER: order_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_reg <= ptrf_pkg::SRC_EULER;
            order_reg  <= ptrf_pkg::ORD_XYZ;
        end else begin
            source_reg <= source_next;
            order_reg  <= order_next;
        end
    end

    // the pipeline moves whenever its last stage is empty or hands off
    assign en       = !vf || load;
    assign s_tready = en;

    always_comb begin
        side_in.tx     = s_tdata[31:0];
        side_in.ty     = s_tdata[63:32];
        side_in.tz     = s_tdata[95:64];
        side_in.qw     = s_tdata[127:96];
        side_in.qi     = s_tdata[159:128];
        side_in.qj     = s_tdata[191:160];
        side_in.qk     = s_tdata[223:192];
        side_in.source = source_reg;
        side_in.order  = order_reg;
    end

    assign vpipe_next = {vpipe_reg[L-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpipe_reg <= '0;
        end else if (en) begin
            vpipe_reg <= vpipe_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < L; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    // one cordic per angle
    ptrf_cordic u_cordic_x (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[248:224]),
        .cos_out (xc),
        .sin_out (xs)
    );

    ptrf_cordic u_cordic_y (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[273:249]),
        .cos_out (yc),
        .sin_out (ys)
    );

    ptrf_cordic u_cordic_z (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[298:274]),
        .cos_out (zc),
        .sin_out (zs)
    );

    // axis rotations and product order
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                mi[i][j] = (i == j) ? ptrf_pkg::ONE_Q30 : '0;
                mx[i][j] = '0;
                my[i][j] = '0;
                mz[i][j] = '0;
            end
        mx[0][0] = ptrf_pkg::ONE_Q30;
        mx[1][1] = xc;
        mx[1][2] = 32'(-xs);
        mx[2][1] = xs;
        mx[2][2] = xc;
        my[0][0] = yc;
        my[0][2] = ys;
        my[1][1] = ptrf_pkg::ONE_Q30;
        my[2][0] = 32'(-ys);
        my[2][2] = yc;
        mz[0][0] = zc;
        mz[0][1] = 32'(-zs);
        mz[1][0] = zs;
        mz[1][1] = zc;
        mz[2][2] = ptrf_pkg::ONE_Q30;

        // unused order codes give the identity, which the products keep exact
        case (side_reg[LC-1].order)
            ptrf_pkg::ORD_XYZ: begin fa = mx; fb = my; fc = mz; end
            ptrf_pkg::ORD_XZY: begin fa = mx; fb = mz; fc = my; end
            ptrf_pkg::ORD_YXZ: begin fa = my; fb = mx; fc = mz; end
            ptrf_pkg::ORD_YZX: begin fa = my; fb = mz; fc = mx; end
            ptrf_pkg::ORD_ZXY: begin fa = mz; fb = mx; fc = my; end
            ptrf_pkg::ORD_ZYX: begin fa = mz; fb = my; fc = mx; end
            default:           begin fa = mi; fb = mi; fc = mi; end
        endcase
    end

    ptrf_matmul u_mm_first (
        .aclk (aclk),
        .en   (en),
        .a    (fa),
        .b    (fb),
        .r    (t_full)
    );

    // third factor waits out the first product
    always_ff @(posedge aclk) begin
        if (en) begin
            c_dly_reg[0] <= fc;
            c_dly_reg[1] <= c_dly_reg[0];
        end
    end

    // partial products of unit rotations stay within Q2.30
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                t_in[i][j] = t_full[i][j][31:0];
    end

    ptrf_matmul u_mm_second (
        .aclk (aclk),
        .en   (en),
        .a    (t_in),
        .b    (c_dly_reg[1]),
        .r    (r_full)
    );

    // quaternion formula, aligned with the second product
    assign qside = side_reg[LC+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg   <= qside.qi * qside.qi;
            y2_reg   <= qside.qj * qside.qj;
            z2_reg   <= qside.qk * qside.qk;
            xy_reg   <= qside.qi * qside.qj;
            xz_reg   <= qside.qi * qside.qk;
            yz_reg   <= qside.qj * qside.qk;
            wx_reg   <= qside.qw * qside.qi;
            wy_reg   <= qside.qw * qside.qj;
            wz_reg   <= qside.qw * qside.qk;
            quat_reg <= quat_next;
        end
    end

    always_comb begin
        quat_next[0][0] = ptrf_pkg::quat_entry(1'b1, -65'(y2_reg), -65'(z2_reg));
        quat_next[0][1] = ptrf_pkg::quat_entry(1'b0, 65'(xy_reg), -65'(wz_reg));
        quat_next[0][2] = ptrf_pkg::quat_entry(1'b0, 65'(xz_reg), 65'(wy_reg));
        quat_next[1][0] = ptrf_pkg::quat_entry(1'b0, 65'(xy_reg), 65'(wz_reg));
        quat_next[1][1] = ptrf_pkg::quat_entry(1'b1, -65'(x2_reg), -65'(z2_reg));
        quat_next[1][2] = ptrf_pkg::quat_entry(1'b0, 65'(yz_reg), -65'(wx_reg));
        quat_next[2][0] = ptrf_pkg::quat_entry(1'b0, 65'(xz_reg), -65'(wy_reg));
        quat_next[2][1] = ptrf_pkg::quat_entry(1'b0, 65'(yz_reg), 65'(wx_reg));
        quat_next[2][2] = ptrf_pkg::quat_entry(1'b1, -65'(x2_reg), -65'(y2_reg));
    end

    // last pipeline stage
    assign fside = side_reg[L-1];
    assign vf    = vpipe_reg[L-1];

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot_fin[i][j] = (fside.source == ptrf_pkg::SRC_QUAT) ? quat_reg[i][j]
                              : ptrf_pkg::sat33(37'(r_full[i][j]));
    end

    // row serializer: takes a new matrix while empty or as the last row of the old one leaves
    assign load = vf && (!ser_valid_reg || (row_reg == ptrf_pkg::LAST_ROW && m_tready));

    always_comb begin
        ser_valid_next = ser_valid_reg;
        row_next       = row_reg;
        if (load) begin
            ser_valid_next = 1'b1;
            row_next       = '0;
        end else if (ser_valid_reg && m_tready) begin
            if (row_reg == ptrf_pkg::LAST_ROW) ser_valid_next = 1'b0;
            else                               row_next = row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            row_reg       <= '0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rot_reg      <= rot_fin;
            trans_reg[0] <= fside.tx;
            trans_reg[1] <= fside.ty;
            trans_reg[2] <= fside.tz;
        end
    end

    // result transaction
    assign m_tvalid = ser_valid_reg;
    assign m_tuser  = row_reg;
    assign m_tlast  = (row_reg == ptrf_pkg::LAST_ROW);
    assign m_tdata  = {5'd0, trans_reg[row_reg], rot_reg[row_reg][2],
                       rot_reg[row_reg][1], rot_reg[row_reg][0]};

endmodule

@@ rtl/ptrf_cordic.sv @@
module ptrf_cordic (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [24:0] angle,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);

    localparam int N = ptrf_pkg::CORDIC_STAGES;
    localparam logic signed [25:0] QUARTER = 26'((ptrf_pkg::DEG_RANGE / 2) * ptrf_pkg::ANGLE_ONE);
    localparam logic signed [25:0] HALF    = 26'(ptrf_pkg::DEG_RANGE * ptrf_pkg::ANGLE_ONE);
    localparam longint RAD_L = ptrf_pkg::RAD_PER_DEG_Q40;
    localparam logic signed [35:0] RAD = RAD_L[35:0];

    logic signed [24:0] a_fold_reg, a_fold_next;
    logic               flip_a_reg, flip_a_next;
    logic signed [25:0] a_ext;
    logic signed [60:0] z_prod;

    logic signed [32:0] x_reg [0:N];
    logic signed [32:0] y_reg [0:N];
    logic signed [59:0] z_reg [0:N];
    logic               flip_reg [0:N];

    logic signed [31:0] cos_reg, cos_next;
    logic signed [31:0] sin_reg, sin_next;

    // fold into +-90 degrees
    always_comb begin
        a_ext = {angle[24], angle};
        flip_a_next = 1'b0;
        a_fold_next = angle;
        if (a_ext > QUARTER) begin
            a_fold_next = 25'(a_ext - HALF);
            flip_a_next = 1'b1;
        end else if (a_ext < -QUARTER) begin
            a_fold_next = 25'(a_ext + HALF);
            flip_a_next = 1'b1;
        end
    end

    assign z_prod = a_fold_reg * RAD;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_fold_reg  <= a_fold_next;
            flip_a_reg  <= flip_a_next;
            x_reg[0]    <= ptrf_pkg::CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_prod[59:0];
            flip_reg[0] <= flip_a_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam longint ATAN_L = ptrf_pkg::atan_q56(i);
        localparam logic signed [59:0] ATAN = ATAN_L[59:0];
        logic signed [32:0] x_next, y_next;
        logic signed [59:0] z_next;

        always_comb begin
            if (z_reg[i] >= 0) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ATAN;
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    always_comb begin
        cos_next = flip_reg[N] ? 32'(-x_reg[N]) : x_reg[N][31:0];
        sin_next = flip_reg[N] ? 32'(-y_reg[N]) : y_reg[N][31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

@@ rtl/ptrf_matmul.sv @@
module ptrf_matmul (
    input  logic             aclk,
    input  logic             en,
    input  ptrf_pkg::mat32_t a,
    input  ptrf_pkg::mat32_t b,
    output ptrf_pkg::mat36_t r
);

    logic signed [63:0] prod_reg  [0:2][0:2][0:2];
    logic signed [63:0] prod_next [0:2][0:2][0:2];
    logic signed [65:0] acc       [0:2][0:2];
    ptrf_pkg::mat36_t   r_reg, r_next;

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    prod_next[i][j][k] = a[i][k] * b[k][j];
    end

    // exact sum, rounded to Q.30 with halves up
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc[i][j] = 66'(prod_reg[i][j][0]) + 66'(prod_reg[i][j][1])
                          + 66'(prod_reg[i][j][2]) + 66'sd536870912;
                r_next[i][j] = 36'(acc[i][j] >>> 30);
            end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            r_reg    <= r_next;
        end
    end

    assign r = r_reg;

endmodule

@@ verif/pose_vector_to_rigid_transform_tb.sv @@
`timescale 1ns / 1ps

module pose_vector_to_rigid_transform_tb;

    // euler_order codes that select no product, the block then gives the identity
    localparam logic [2:0] ORD_SPARE_LO = 3'd6;
    localparam logic [2:0] ORD_SPARE_HI = 3'd7;

    localparam longint UNIT_Q30   = longint'(1) <<< 30;
    localparam int     ANG_MAX    = 11796480;        // 180 degrees in Q9.16
    localparam int     ANG_QUART  = 90 * 65536;
    localparam int     QUAT_MAX   = 1073741824;      // 1.0 in Q2.30
    localparam int     SETTLE_CYC = 40;              // pipeline depth plus margin

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] qw;
        logic signed [31:0] qi;
        logic signed [31:0] qj;
        logic signed [31:0] qk;
        logic signed [24:0] ax;
        logic signed [24:0] ay;
        logic signed [24:0] az;
    } pose_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [32:0] c0;
        logic signed [32:0] c1;
        logic signed [32:0] c2;
        logic signed [31:0] shift;
        logic               last;
    } row_t;

    // one directed stimulus row: the setting, the pose, and whether the
    // expected matrix is simply the identity
    typedef struct {
        logic       src;
        logic [2:0] ord;
        pose_t      p;
        bit         ident;
    } dir_row_t;

    typedef longint m3_t [0:2][0:2];

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [303:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [135:0]   m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;
    logic           cfg_wr_en = 1'b0;
    logic           cfg_index = 1'b0;
    logic [2:0]     cfg_wdata = '0;

    pose_vector_to_rigid_transform dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // expected rows, oldest first
    row_t       pending_rows[$];
    int         fail_cnt = 0;
    logic       cur_src = ptrf_pkg::SRC_EULER;
    logic [2:0] cur_ord = ptrf_pkg::ORD_XYZ;
    int         burst_left = 0;

    // angle tables: atan(2^-i) in Q.56 and radians per degree in Q.40
    longint     arctan_q56[0:ptrf_pkg::CORDIC_STAGES-1];
    longint     deg_to_rad_q40;

    function automatic longint arccot_q60(longint m);
        longint t;
        longint acc;
        longint k;
        bit     neg;
        t = (longint'(1) <<< 60) / m;
        acc = 0;
        k = 1;
        neg = 1'b0;
        while (t > 0) begin
            acc = neg ? acc - t / k : acc + t / k;
            neg = !neg;
            t = t / (m * m);
            k = k + 2;
        end
        return acc;
    endfunction

    function automatic void build_angle_tables();
        longint pi56;
        longint acc;
        longint k;
        int     e;
        bit     neg;
        pi56 = (16 * arccot_q60(5) - 4 * arccot_q60(239) + 8) >>> 4;
        deg_to_rad_q40 = pi56 / (180 * 65536);
        arctan_q56[0] = (pi56 + 2) >>> 2;
        for (int i = 1; i < ptrf_pkg::CORDIC_STAGES; i++) begin
            acc = 0;
            k = 1;
            neg = 1'b0;
            e = 56 - i;
            while (e >= 0) begin
                acc = neg ? acc - (longint'(1) <<< e) / k : acc + (longint'(1) <<< e) / k;
                neg = !neg;
                k = k + 2;
                e = e - 2 * i;
            end
            arctan_q56[i] = acc;
        end
    endfunction

    function automatic longint clamp33(longint v);
        if (v > 64'sd4294967295) return 64'sd4294967295;
        if (v < -64'sd4294967296) return -64'sd4294967296;
        return v;
    endfunction

    // rotated cordic, angle folded into +-90 degrees first
    function automatic void angle_sin_cos(input longint ang, output longint co,
                                          output longint si);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = ptrf_pkg::CORDIC_GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (ang > ANG_QUART) begin
            ang = ang - 2 * ANG_QUART;
            flip = 1'b1;
        end else if (ang < -ANG_QUART) begin
            ang = ang + 2 * ANG_QUART;
            flip = 1'b1;
        end
        z = ang * deg_to_rad_q40;
        for (int i = 0; i < ptrf_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q56[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q56[i];
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    function automatic m3_t mat_product(m3_t a, m3_t b);
        m3_t    r;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc = acc + a[i][k] * b[k][j];
                r[i][j] = (acc + (UNIT_Q30 >>> 1)) >>> 30;
            end
        return r;
    endfunction

    // diag + 2*(e1 + e2) from Q.60 down to Q.30, halves rounded up
    function automatic longint quat_term(bit diag, longint e1, longint e2);
        longint h1;
        longint h2;
        longint l1;
        longint l2;
        h1 = e1 >>> 30;
        h2 = e2 >>> 30;
        l1 = e1 - h1 * UNIT_Q30;
        l2 = e2 - h2 * UNIT_Q30;
        return clamp33((diag ? UNIT_Q30 : 0) + 2 * (h1 + h2)
                       + ((2 * (l1 + l2) + (UNIT_Q30 >>> 1)) >>> 30));
    endfunction

    function automatic m3_t pose_rotation(pose_t p, logic src, logic [2:0] ord);
        m3_t    rot;
        m3_t    mx;
        m3_t    my;
        m3_t    mz;
        longint w, x, y, z;
        longint xc, xs, yc, ys, zc, zs;
        if (src == ptrf_pkg::SRC_QUAT) begin
            w = p.qw;
            x = p.qi;
            y = p.qj;
            z = p.qk;
            rot[0][0] = quat_term(1, -y * y, -z * z);
            rot[0][1] = quat_term(0, x * y, -w * z);
            rot[0][2] = quat_term(0, x * z, w * y);
            rot[1][0] = quat_term(0, x * y, w * z);
            rot[1][1] = quat_term(1, -x * x, -z * z);
            rot[1][2] = quat_term(0, y * z, -w * x);
            rot[2][0] = quat_term(0, x * z, -w * y);
            rot[2][1] = quat_term(0, y * z, w * x);
            rot[2][2] = quat_term(1, -x * x, -y * y);
            return rot;
        end
        angle_sin_cos(longint'(p.ax), xc, xs);
        angle_sin_cos(longint'(p.ay), yc, ys);
        angle_sin_cos(longint'(p.az), zc, zs);
        mx = '{'{UNIT_Q30, 0, 0}, '{0, xc, -xs}, '{0, xs, xc}};
        my = '{'{yc, 0, ys}, '{0, UNIT_Q30, 0}, '{-ys, 0, yc}};
        mz = '{'{zc, -zs, 0}, '{zs, zc, 0}, '{0, 0, UNIT_Q30}};
        case (ord)
            ptrf_pkg::ORD_XYZ: rot = mat_product(mat_product(mx, my), mz);
            ptrf_pkg::ORD_XZY: rot = mat_product(mat_product(mx, mz), my);
            ptrf_pkg::ORD_YXZ: rot = mat_product(mat_product(my, mx), mz);
            ptrf_pkg::ORD_YZX: rot = mat_product(mat_product(my, mz), mx);
            ptrf_pkg::ORD_ZXY: rot = mat_product(mat_product(mz, mx), my);
            ptrf_pkg::ORD_ZYX: rot = mat_product(mat_product(mz, my), mx);
            default: rot = '{'{UNIT_Q30, 0, 0}, '{0, UNIT_Q30, 0}, '{0, 0, UNIT_Q30}};
        endcase
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) rot[r][c] = clamp33(rot[r][c]);
        return rot;
    endfunction

    function automatic void queue_rows(pose_t p, m3_t rot);
        row_t e;
        for (int r = 0; r < 3; r++) begin
            e.row   = 2'(r);
            e.c0    = rot[r][0][32:0];
            e.c1    = rot[r][1][32:0];
            e.c2    = rot[r][2][32:0];
            e.shift = (r == 0) ? p.tx : (r == 1) ? p.ty : p.tz;
            e.last  = (e.row == ptrf_pkg::LAST_ROW);
            pending_rows = {pending_rows, e};
        end
    endfunction

    function automatic logic [303:0] pack_pose(pose_t p);
        return {5'b0, p.az, p.ay, p.ax, p.qk, p.qj, p.qi, p.qw, p.tz, p.ty, p.tx};
    endfunction

    function automatic dir_row_t dir_row(logic src, logic [2:0] ord,
                                         int qw, int qi, int qj, int qk,
                                         int ax, int ay, int az, bit ident);
        dir_row_t d;
        d.src = src;
        d.ord = ord;
        d.p.tx = $urandom;
        d.p.ty = $urandom;
        d.p.tz = $urandom;
        d.p.qw = qw;
        d.p.qi = qi;
        d.p.qj = qj;
        d.p.qk = qk;
        d.p.ax = 25'(ax);
        d.p.ay = 25'(ay);
        d.p.az = 25'(az);
        d.ident = ident;
        return d;
    endfunction

    // value in range, with the corners picked now and then
    function automatic int pick_signed(int lim, int quarter);
        case ($urandom_range(0, 11))
            0: return lim;
            1: return -lim;
            2: return quarter;
            3: return -quarter - 1;
            4: return 0;
            default: return int'($urandom_range(0, 2 * lim)) - lim;
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        p.tx = $urandom;
        p.ty = $urandom;
        p.tz = $urandom;
        p.qw = pick_signed(QUAT_MAX, QUAT_MAX / 2);
        p.qi = pick_signed(QUAT_MAX, QUAT_MAX / 2);
        p.qj = pick_signed(QUAT_MAX, QUAT_MAX / 2);
        p.qk = pick_signed(QUAT_MAX, QUAT_MAX / 2);
        p.ax = 25'(pick_signed(ANG_MAX, ANG_QUART));
        p.ay = 25'(pick_signed(ANG_MAX, ANG_QUART));
        p.az = 25'(pick_signed(ANG_MAX, ANG_QUART));
        return p;
    endfunction

    // wait until every row has come out, then let the pipeline go quiet
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // writes both registers; junk goes into the unused upper data bits
    task automatic write_config(logic src, logic [2:0] ord);
        drain_pipeline();
        cfg_wr_en <= 1'b1;
        cfg_index <= ptrf_pkg::REG_ROT_SOURCE;
        cfg_wdata <= {2'($urandom), src};
        @(posedge aclk);
        cfg_index <= ptrf_pkg::REG_EULER_ORDER;
        cfg_wdata <= ord;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_src = src;
        cur_ord = ord;
    endtask

    // one transaction on the input channel, rows queued as it is accepted
    task automatic send_pose(pose_t p, bit ident);
        m3_t eye;
        eye = '{'{UNIT_Q30, 0, 0}, '{0, UNIT_Q30, 0}, '{0, 0, UNIT_Q30}};
        if (burst_left == 0) burst_left = ($urandom_range(0, 4) == 0) ?
                                          $urandom_range(20, 50) : $urandom_range(1, 8);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pose(p);
        do @(posedge aclk); while (!s_tready);
        queue_rows(p, ident ? eye : pose_rotation(p, cur_src, cur_ord));
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // result channel back-pressure: stretches of full rate, light and heavy stalls
    int ready_cyc = 0;
    always @(posedge aclk) begin
        ready_cyc <= ready_cyc + 1;
        case ((ready_cyc / 300) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        row_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result transaction, row %0d", m_tuser);
                fail_cnt++;
            end else begin
                e = pending_rows.pop_front();
                if (m_tuser != e.row) begin
                    $error("row_number expected %0d got %0d", e.row, m_tuser);
                    fail_cnt++;
                end
                if ($signed(m_tdata[32:0]) != e.c0) begin
                    $error("rot_first expected %0d got %0d", e.c0, $signed(m_tdata[32:0]));
                    fail_cnt++;
                end
                if ($signed(m_tdata[65:33]) != e.c1) begin
                    $error("rot_second expected %0d got %0d", e.c1, $signed(m_tdata[65:33]));
                    fail_cnt++;
                end
                if ($signed(m_tdata[98:66]) != e.c2) begin
                    $error("rot_third expected %0d got %0d", e.c2, $signed(m_tdata[98:66]));
                    fail_cnt++;
                end
                if ($signed(m_tdata[130:99]) != e.shift) begin
                    $error("shift_entry expected %0d got %0d", e.shift,
                           $signed(m_tdata[130:99]));
                    fail_cnt++;
                end
                if (m_tlast != e.last) begin
                    $error("row_last expected %0d got %0d", e.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        dir_row_t dir_tab[$];
        logic     src;
        logic [2:0] ord;
        build_angle_tables();

        // quaternion mode: unit and zero quaternions give the identity,
        // full-scale components saturate
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, QUAT_MAX,
                                    0, 0, 0, 0, 0, 0, 1)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, 0,
                                    0, 0, 0, ANG_MAX, 0, 0, 1)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, -QUAT_MAX,
                                    0, 0, 0, 0, 0, 0, 1)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, QUAT_MAX,
                                    QUAT_MAX, QUAT_MAX, QUAT_MAX, 0, 0, 0, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, -QUAT_MAX,
                                    -QUAT_MAX, -QUAT_MAX, -QUAT_MAX, 0, 0, 0, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, QUAT_MAX,
                                    -QUAT_MAX, QUAT_MAX, -QUAT_MAX, 0, 0, 0, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_QUAT, ptrf_pkg::ORD_XYZ, 759250125,
                                    379625062, -379625062, 379625062, 0, 0, 0, 0)};
        // euler mode, every product order, fold beyond +-90 degrees
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_XYZ, QUAT_MAX,
                                    QUAT_MAX, 0, 0, 0, 0, 0, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_XYZ, 0, 0, 0, 0,
                                    ANG_QUART, -ANG_QUART, ANG_QUART + 1, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_XZY, 0, 0, 0, 0,
                                    ANG_MAX, -ANG_MAX, -ANG_QUART - 1, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_YXZ, 0, 0, 0, 0,
                                    1966080, 2949120, -3932160, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_YZX, 0, 0, 0, 0,
                                    -ANG_MAX, ANG_MAX, ANG_MAX, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_ZXY, 0, 0, 0, 0,
                                    10000000, -10000000, 1, 0)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ptrf_pkg::ORD_ZYX, 0, 0, 0, 0,
                                    -1, 6000000, -ANG_QUART, 0)};
        // unused order codes give the identity whatever the angles
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ORD_SPARE_LO, 0, 0, 0, 0,
                                    ANG_MAX, 123456, -ANG_MAX, 1)};
        dir_tab = {dir_tab, dir_row(ptrf_pkg::SRC_EULER, ORD_SPARE_HI, 0, 0, 0, 0,
                                    -ANG_MAX, ANG_QUART, ANG_MAX, 1)};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].src != cur_src || dir_tab[i].ord != cur_ord)
                write_config(dir_tab[i].src, dir_tab[i].ord);
            send_pose(dir_tab[i].p, dir_tab[i].ident);
        end

        // random phases, each under its own setting
        for (int ph = 0; ph < 6; ph++) begin
            src = (ph % 2 == 0) ? ptrf_pkg::SRC_EULER : ptrf_pkg::SRC_QUAT;
            if (ph == 5) src = 1'($urandom);
            ord = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            write_config(src, ord);
            for (int n = 0; n < 60; n++) begin
                if (ph == 2 && n == 30) drain_pipeline();
                send_pose(random_pose(), 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
